// ===== rtl/jbe_pkg.sv =====
// Shared types and constants for the serial-bus EEPROM command unit.
package jbe_pkg;

   localparam int LINE_COUNT_DEFAULT = 256;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [0:0] REG_SAVE_KIND = 1'b0;

   // Command codes.
   localparam logic [7:0] OP_CHECK      = 8'h00;
   localparam logic [7:0] OP_READ       = 8'h04;
   localparam logic [7:0] OP_WRITE      = 8'h05;
   localparam logic [7:0] OP_RTC_STATUS = 8'h06;
   localparam logic [7:0] OP_RTC_READ   = 8'h07;
   localparam logic [7:0] OP_RTC_WRITE  = 8'h08;

   // Save kind codes.
   localparam logic [1:0] SAVE_EEP_4K  = 2'd0;
   localparam logic [1:0] SAVE_EEP_16K = 2'd1;

   // Frame byte constants.
   localparam logic [7:0] LEN_NO_DEVICE   = 8'h80;
   localparam logic [7:0] LEN_SIZE_ERROR  = 8'h40;
   localparam logic [7:0] TYPE_EEP_4K     = 8'h80;
   localparam logic [7:0] TYPE_EEP_16K    = 8'hc0;
   localparam logic [7:0] RTC_STATUS_BYTE = 8'h10;
   localparam logic [7:0] RTC_BLOCK0_BYTE = 8'h02;
   localparam logic [7:0] ERASED_BYTE     = 8'hff;

   typedef struct packed {
      logic [7:0]  op;
      logic [7:0]  rx_len;
      logic [7:0]  block_byte;
      logic [63:0] data;
      logic [7:0]  tail_byte;
   } frame_type;

   typedef struct packed {
      logic [7:0]  rx_len_out;
      logic [7:0]  block_out;
      logic [63:0] data_out;
      logic [7:0]  tail_out;
   } result_type;

endpackage

// ===== rtl/jbe_if.sv =====
// Valid/ready channel interfaces for command frames and answered frames.
interface jbe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  op;
   logic [7:0]  rx_len;
   logic [7:0]  block_byte;
   logic [63:0] data_in;
   logic [7:0]  tail_byte;

   modport source (output valid, op, rx_len, block_byte, data_in, tail_byte, input ready);
   modport sink (input valid, op, rx_len, block_byte, data_in, tail_byte, output ready);
endinterface

interface jbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_len_out;
   logic [7:0]  block_out;
   logic [63:0] data_out;
   logic [7:0]  tail_out;

   modport source (output valid, rx_len_out, block_out, data_out, tail_out, input ready);
   modport sink (input valid, rx_len_out, block_out, data_out, tail_out, output ready);
endinterface

// ===== rtl/jbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module jbe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/jbe_frame_alu.sv =====
// Rewrites one command frame according to its command code.
module jbe_frame_alu (
   input  jbe_pkg::frame_type  frame,
   input  logic [1:0]          save_kind,
   input  logic                line_hit,
   input  logic [63:0]         line_data,
   output jbe_pkg::result_type result
);

   logic [7:0]  type_byte;
   logic [1:0]  len_low;
   logic        is_eeprom;

   assign type_byte = (save_kind == jbe_pkg::SAVE_EEP_16K) ? jbe_pkg::TYPE_EEP_16K
                                                          : jbe_pkg::TYPE_EEP_4K;
   assign len_low   = frame.rx_len[1:0];
   assign is_eeprom = (save_kind == jbe_pkg::SAVE_EEP_4K) ||
                      (save_kind == jbe_pkg::SAVE_EEP_16K);

   always_comb begin
      result.rx_len_out = frame.rx_len;
      result.block_out  = frame.block_byte;
      result.data_out   = frame.data;
      result.tail_out   = frame.tail_byte;
      case (frame.op)
         jbe_pkg::OP_CHECK: begin
            if (!is_eeprom) begin
               result.rx_len_out = frame.rx_len | jbe_pkg::LEN_NO_DEVICE;
            end else if (frame.rx_len != 8'd3) begin
               // A length other than three answers only as many bytes as its low two bits ask for.
               result.rx_len_out = frame.rx_len | jbe_pkg::LEN_SIZE_ERROR;
               if (len_low > 2'd0) begin
                  result.block_out = 8'h00;
               end
               if (len_low > 2'd1) begin
                  result.data_out[7:0] = type_byte;
               end
               if (len_low > 2'd2) begin
                  result.data_out[15:8] = 8'h00;
               end
            end else begin
               result.block_out      = 8'h00;
               result.data_out[7:0]  = type_byte;
               result.data_out[15:8] = 8'h00;
            end
         end
         jbe_pkg::OP_READ: begin
            // Lines never written, and lines past the end, read as erased.
            result.data_out = line_hit ? line_data : {8{jbe_pkg::ERASED_BYTE}};
         end
         jbe_pkg::OP_RTC_STATUS: begin
            result.block_out      = 8'h00;
            result.data_out[7:0]  = jbe_pkg::RTC_STATUS_BYTE;
            result.data_out[15:8] = 8'h00;
         end
         jbe_pkg::OP_RTC_READ: begin
            if (frame.block_byte == 8'h00) begin
               result.data_out[7:0]  = 8'h00;
               result.data_out[15:8] = jbe_pkg::RTC_BLOCK0_BYTE;
               result.tail_out       = 8'h00;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/joybus_eeprom_command_unit.sv =====
// Top level of the serial-bus EEPROM command unit.
// One command frame is answered per transfer. A frame is taken into a stage register at the
// same edge that its line is read from the line RAM; the answered frame moves on into the
// output register when it is free or drains, so the unit sustains one frame per cycle while
// the output is not stalled. The stage register covers the RAM's registered read port. Writes
// go into the RAM at the edge the frame is taken, so a following read of the same line sees
// them. Each line has a valid bit that reset clears at once; a line without it reads as all
// 0xFF, so no clearing pass follows reset. The save kind register lies at byte address 0.
module joybus_eeprom_command_unit #(
   parameter int LINE_COUNT = jbe_pkg::LINE_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   jbe_req_if.sink                         req,
   jbe_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [jbe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [jbe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [jbe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int         ADDR_W     = $clog2(LINE_COUNT);
   localparam logic [8:0] LINE_LIMIT = 9'(LINE_COUNT);

   logic [1:0]              save_kind_ff, save_kind_in;
   logic [LINE_COUNT-1:0]   line_valid_ff, line_valid_in;
   logic                    s1_valid_ff, s1_valid_in;
   jbe_pkg::frame_type      s1_frame_ff, s1_frame_in;
   logic                    s1_hit_ff, s1_hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   jbe_pkg::result_type     rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    rsp_load;
   logic                    in_range;
   logic [ADDR_W-1:0]       line_addr;
   logic                    wr_en;
   logic [63:0]             line_data;
   logic                    csr_write;
   logic                    csr_sel_kind;

   // Configuration port.
   assign pready       = 1'b1;
   assign csr_sel_kind = (paddr[2] == jbe_pkg::REG_SAVE_KIND);
   assign csr_write    = psel && penable && pwrite && pready;
   assign prdata       = csr_sel_kind ? {{(jbe_pkg::CSR_DATA_W-2){1'b0}}, save_kind_ff}
                                      : '0;
   assign save_kind_in = (csr_write && csr_sel_kind) ? pwdata[1:0] : save_kind_ff;

   // Handshake: the stage moves on whenever the output register is free or drains.
   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !reset && (!s1_valid_ff || rsp_load);
   assign accept    = req.valid && req.ready;

   assign in_range  = ({1'b0, req.block_byte} < LINE_LIMIT);
   assign line_addr = req.block_byte[ADDR_W-1:0];
   assign wr_en     = accept && (req.op == jbe_pkg::OP_WRITE) && in_range;

   always_comb begin
      line_valid_in = line_valid_ff;
      if (wr_en) begin
         line_valid_in[line_addr] = 1'b1;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (rsp_load ? 1'b0 : s1_valid_ff);
   assign s1_hit_in   = accept ? (in_range && line_valid_ff[line_addr]) : s1_hit_ff;

   always_comb begin
      s1_frame_in = s1_frame_ff;
      if (accept) begin
         s1_frame_in.op         = req.op;
         s1_frame_in.rx_len     = req.rx_len;
         s1_frame_in.block_byte = req.block_byte;
         s1_frame_in.data       = req.data_in;
         s1_frame_in.tail_byte  = req.tail_byte;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   jbe_ram #(
      .WIDTH (64),
      .DEPTH (LINE_COUNT)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (line_addr),
      .wr_data (req.data_in),
      .rd_en   (accept),
      .rd_addr (line_addr),
      .rd_data (line_data)
   );

   jbe_pkg::result_type alu_result;

   jbe_frame_alu u_frame_alu (
      .frame     (s1_frame_ff),
      .save_kind (save_kind_ff),
      .line_hit  (s1_hit_ff),
      .line_data (line_data),
      .result    (alu_result)
   );

   assign rsp_data_in = rsp_load ? alu_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         save_kind_ff  <= jbe_pkg::SAVE_EEP_4K;
         line_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         save_kind_ff  <= save_kind_in;
         line_valid_ff <= line_valid_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_frame_ff <= s1_frame_in;
      s1_hit_ff   <= s1_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.rx_len_out = rsp_data_ff.rx_len_out;
   assign rsp.block_out  = rsp_data_ff.block_out;
   assign rsp.data_out   = rsp_data_ff.data_out;
   assign rsp.tail_out   = rsp_data_ff.tail_out;

   // A stalled stage with a full, stalled output register must block new frames.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("frame taken while the pipeline is stalled");

   // A written line is marked valid from the next cycle on.
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> line_valid_ff[$past(line_addr)])
      else $error("written line not marked valid");

   // Reset leaves every line erased and the pipeline empty.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (line_valid_ff == '0 && !s1_valid_ff && !rsp_valid_ff))
      else $error("state not cleared by reset");

   // A taken frame always occupies the stage in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("taken frame lost");

endmodule
